[src/model_transform_composer_core_assert.svh]
// assertion macros for the transform composer
`ifndef MODEL_TRANSFORM_COMPOSER_CORE_ASSERT_SVH
`define MODEL_TRANSFORM_COMPOSER_CORE_ASSERT_SVH
// implication checked on every clock edge outside reset
`define MTC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define MTC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[src/mtc_pkg.sv]
// shared types, constants and functions of the transform composer
package mtc_pkg;
  localparam int CordicSteps = 24;
  localparam int CntW = $clog2(CordicSteps + 1);
  localparam logic signed [31:0] OneQ16 = 32'sh10000;
  localparam logic signed [63:0] CordicGain = 64'sd652032874;
  // reciprocals for the division by 45 in the angle conversion
  localparam logic [31:0] Recip45 = 32'd3054198967;
  localparam logic [19:0] Recip45Small = 20'd745655;

  typedef enum logic [2:0] {
    REQ_IDENT = 3'd0, REQ_SCALE = 3'd1, REQ_TRANS = 3'd2,
    REQ_ROTX = 3'd3, REQ_ROTY = 3'd4, REQ_ROTZ = 3'd5,
    REQ_RSV6 = 3'd6, REQ_RSV7 = 3'd7
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ANGLE, ST_CORDIC, ST_UPD, ST_EMIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic angle;
    logic cstep;
    logic upd;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic adone;
    logic cdone;
    logic udone;
    logic edone;
    logic is_rot;
  } sts_t;

  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    logic [31:0] t;
    begin
      unique case (i)
        5'd0: t = 32'h20000000;  5'd1: t = 32'h12E4051E;
        5'd2: t = 32'h09FB385B;  5'd3: t = 32'h051111D4;
        5'd4: t = 32'h028B0D43;  5'd5: t = 32'h0145D7E1;
        5'd6: t = 32'h00A2F61E;  5'd7: t = 32'h00517C55;
        5'd8: t = 32'h0028BE53;  5'd9: t = 32'h00145F2F;
        5'd10: t = 32'h000A2F98; 5'd11: t = 32'h000517CC;
        5'd12: t = 32'h00028BE6; 5'd13: t = 32'h000145F3;
        5'd14: t = 32'h0000A2FA; 5'd15: t = 32'h0000517D;
        5'd16: t = 32'h000028BE; 5'd17: t = 32'h0000145F;
        5'd18: t = 32'h00000A30; 5'd19: t = 32'h00000518;
        5'd20: t = 32'h0000028C; 5'd21: t = 32'h00000146;
        5'd22: t = 32'h000000A3; 5'd23: t = 32'h00000051;
        5'd24: t = 32'h00000029; 5'd25: t = 32'h00000014;
        5'd26: t = 32'h0000000A; 5'd27: t = 32'h00000005;
        5'd28: t = 32'h00000003; 5'd29: t = 32'h00000001;
        default: t = 32'h0;
      endcase
      return t;
    end
  endfunction

  // q32 sum to q16.16, round half up, saturate
  function automatic logic [31:0] rnd16(input logic signed [65:0] x);
    logic signed [65:0] q;
    begin
      q = (x + 66'sd32768) >>> 16;
      if (q > 66'sh7FFFFFFF) return 32'h7FFFFFFF;
      else if (q < -66'sh80000000) return 32'h80000000;
      else return q[31:0];
    end
  endfunction
endpackage

[src/mtc_if.sv]
// valid/ready channel interfaces
interface mtc_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic signed [31:0] arg_x;
  logic signed [31:0] arg_y;
  logic signed [31:0] arg_z;
  logic signed [31:0] angle_deg;
  modport source (output valid, req_type, arg_x, arg_y, arg_z, angle_deg, input ready);
  modport sink (input valid, req_type, arg_x, arg_y, arg_z, angle_deg, output ready);
endinterface

interface mtc_elem_if;
  logic        valid;
  logic        ready;
  logic [3:0]  elem_index;
  logic signed [31:0] elem_value;
  logic        last_elem;
  modport source (output valid, elem_index, elem_value, last_elem, input ready);
  modport sink (input valid, elem_index, elem_value, last_elem, output ready);
endinterface

[src/mtc_ctrl.sv]
// request sequencer state machine
module mtc_ctrl import mtc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  sts_t  sts_i,
  output cmd_t  cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_ANGLE;
      ST_ANGLE: begin
        if (!sts_i.is_rot) state_d = ST_UPD;
        else if (sts_i.adone) state_d = ST_CORDIC;
      end
      ST_CORDIC: if (sts_i.cdone) state_d = ST_UPD;
      ST_UPD:    if (sts_i.udone) state_d = ST_EMIT;
      ST_EMIT:   if (sts_i.edone) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_ANGLE:  cmd_o.angle = 1'b1;
      ST_CORDIC: cmd_o.cstep = 1'b1;
      ST_UPD:    cmd_o.upd = 1'b1;
      ST_EMIT:   cmd_o.emit = 1'b1;
      default: ;
    endcase
  end
endmodule

[src/mtc_dp.sv]
// matrix store, cordic and element update datapath
module mtc_dp import mtc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [2:0]  req_type_i,
  input  logic signed [31:0] arg_x_i,
  input  logic signed [31:0] arg_y_i,
  input  logic signed [31:0] arg_z_i,
  input  logic signed [31:0] angle_deg_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  elem_index_o,
  output logic [31:0] elem_value_o,
  output logic        last_elem_o
);
  logic [31:0] mat_q [16];
  logic [2:0] typ_q;
  logic signed [31:0] ax_q, ay_q, az_q, deg_q;
  logic signed [63:0] cx_q, cy_q, cz_q;
  logic neg_q;
  logic [CntW-1:0] cnt_q;
  logic [2:0] ucnt_q;   // column pass 0..3, two phases per column
  logic [4:0] ecnt_q;
  logic ovld_q;
  logic [3:0] oidx_q;
  logic [31:0] oval_q;
  logic signed [31:0] sn_q, cs_q;
  logic signed [63:0] pa_q, pb_q, pc_q, pd_q;

  logic is_rot;
  assign is_rot = (typ_q == REQ_ROTX) || (typ_q == REQ_ROTY) || (typ_q == REQ_ROTZ);

  // degrees to binary angle: round(deg*65536/360)
  // equals floor((8192*deg + 22) / 45), with deg split as 45*a + b
  logic [1:0] acnt_q;
  logic dneg_q;
  logic [31:0] ux_q;
  logic [63:0] pr_q;
  logic [18:0] aq_q, yq_q;
  logic [26:0] a_w;
  logic signed [27:0] as_w;
  logic [31:0] b_w;
  logic [38:0] t_w;
  logic [31:0] bam32_w;
  logic signed [63:0] bam_w, z0_w;
  always_comb begin
    a_w = pr_q[63:37];
    as_w = dneg_q ? -$signed({1'b0, a_w}) : $signed({1'b0, a_w});
    b_w = 32'(deg_q) - 32'(as_w) * 32'd45;
    t_w = 39'(yq_q) * 39'(Recip45Small);
    bam32_w = {aq_q, 13'd0} + 32'(t_w[38:25]);
    bam_w = 64'(signed'(bam32_w));
    z0_w = bam_w;
    if (bam_w >= 64'sh40000000) z0_w = bam_w - 64'sh80000000;
    else if (bam_w < -64'sh40000000) z0_w = bam_w + 64'sh80000000;
  end

  // sin/cos from cordic result
  function automatic logic signed [31:0] q30q16(input logic signed [63:0] v);
    logic signed [63:0] r;
    begin
      r = (v + 64'sd8192) >>> 14;
      if (r > 64'sd65536) r = 64'sd65536;
      if (r < -64'sd65536) r = -64'sd65536;
      return r[31:0];
    end
  endfunction

  logic [1:0] ra, rb;
  always_comb begin
    unique case (typ_q)
      REQ_ROTX: begin ra = 2'd1; rb = 2'd2; end
      REQ_ROTY: begin ra = 2'd2; rb = 2'd0; end
      default:  begin ra = 2'd0; rb = 2'd1; end
    endcase
  end

  logic [1:0] col;
  logic ph;
  assign col = ucnt_q[2:1];
  assign ph = ucnt_q[0];
  logic signed [31:0] m0, m1, m2, m3, ma, mb;
  assign m0 = mat_q[{col, 2'd0}];
  assign m1 = mat_q[{col, 2'd1}];
  assign m2 = mat_q[{col, 2'd2}];
  assign m3 = mat_q[{col, 2'd3}];
  assign ma = mat_q[{col, ra}];
  assign mb = mat_q[{col, rb}];

  assign sts_o.is_rot = is_rot;
  assign sts_o.adone = (acnt_q == 2'd3);
  assign sts_o.cdone = (cnt_q == CntW'(CordicSteps));
  assign sts_o.udone = (ucnt_q == 3'd7);
  assign sts_o.edone = out_valid_o && out_ready_i && (oidx_q == 4'd15);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      typ_q <= req_type_i;
      ax_q <= arg_x_i;
      ay_q <= arg_y_i;
      az_q <= arg_z_i;
      deg_q <= angle_deg_i;
    end
    if (cmd_i.angle) begin
      unique case (acnt_q)
        2'd0: begin
          dneg_q <= deg_q[31];
          ux_q <= deg_q[31] ? (32'(-deg_q) + 32'd44) : 32'(deg_q);
        end
        2'd1: pr_q <= 64'(ux_q) * 64'(Recip45);
        2'd2: begin
          aq_q <= as_w[18:0];
          yq_q <= {b_w[5:0], 13'd0} + 19'd22;
        end
        2'd3: begin
          cx_q <= CordicGain;
          cy_q <= '0;
          cz_q <= z0_w;
          neg_q <= (z0_w != bam_w);
        end
      endcase
    end
    if (cmd_i.cstep) begin
      if (cnt_q != CntW'(CordicSteps)) begin
        if (cz_q >= 0) begin
          cx_q <= cx_q - (cy_q >>> cnt_q);
          cy_q <= cy_q + (cx_q >>> cnt_q);
          cz_q <= cz_q - 64'(atan_bam(5'(cnt_q)));
        end else begin
          cx_q <= cx_q + (cy_q >>> cnt_q);
          cy_q <= cy_q - (cx_q >>> cnt_q);
          cz_q <= cz_q + 64'(atan_bam(5'(cnt_q)));
        end
      end else begin
        cs_q <= neg_q ? -q30q16(cx_q) : q30q16(cx_q);
        sn_q <= neg_q ? -q30q16(cy_q) : q30q16(cy_q);
      end
    end
    if (cmd_i.upd && !ph) begin
      // phase 0: products
      if (is_rot) begin
        pa_q <= 64'(cs_q) * 64'(ma);
        pb_q <= 64'(sn_q) * 64'(mb);
        pc_q <= 64'(sn_q) * 64'(ma);
        pd_q <= 64'(cs_q) * 64'(mb);
      end else if (typ_q == REQ_SCALE) begin
        pa_q <= 64'(ax_q) * 64'(m0);
        pb_q <= 64'(ay_q) * 64'(m1);
        pc_q <= 64'(az_q) * 64'(m2);
      end else begin
        pa_q <= 64'(ax_q) * 64'(m3);
        pb_q <= 64'(ay_q) * 64'(m3);
        pc_q <= 64'(az_q) * 64'(m3);
      end
    end
    if (cmd_i.upd && ph) begin
      unique case (typ_q)
        REQ_IDENT: for (int k = 0; k < 4; k++)
          mat_q[{col, 2'(k)}] <= (k == int'(col)) ? OneQ16 : 32'sd0;
        REQ_SCALE: begin
          mat_q[{col, 2'd0}] <= rnd16(66'(pa_q));
          mat_q[{col, 2'd1}] <= rnd16(66'(pb_q));
          mat_q[{col, 2'd2}] <= rnd16(66'(pc_q));
        end
        REQ_TRANS: begin
          mat_q[{col, 2'd0}] <= rnd16((66'(m0) <<< 16) + 66'(pa_q));
          mat_q[{col, 2'd1}] <= rnd16((66'(m1) <<< 16) + 66'(pb_q));
          mat_q[{col, 2'd2}] <= rnd16((66'(m2) <<< 16) + 66'(pc_q));
        end
        REQ_ROTX, REQ_ROTY, REQ_ROTZ: begin
          mat_q[{col, ra}] <= rnd16(66'(pa_q) - 66'(pb_q));
          mat_q[{col, rb}] <= rnd16(66'(pc_q) + 66'(pd_q));
        end
        default: ;
      endcase
    end
    if (cmd_i.emit && (!ovld_q || out_ready_i)) begin
      oidx_q <= ecnt_q[3:0];
      oval_q <= mat_q[ecnt_q[3:0]];
    end
  end

  // the matrix is not reset here; the top injects an identity request after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acnt_q <= '0;
      cnt_q <= '0;
      ucnt_q <= '0;
      ecnt_q <= '0;
      ovld_q <= 1'b0;
    end else begin
      if (cmd_i.angle) acnt_q <= acnt_q + 2'd1;
      else acnt_q <= '0;
      if (cmd_i.cstep) cnt_q <= cnt_q + CntW'(1);
      else cnt_q <= '0;
      if (cmd_i.upd) ucnt_q <= ucnt_q + 3'd1;
      else ucnt_q <= '0;
      if (cmd_i.emit) begin
        if (!ovld_q || out_ready_i) begin
          if (ecnt_q < 5'd16) begin
            ovld_q <= 1'b1;
            ecnt_q <= ecnt_q + 5'd1;
          end else begin
            ovld_q <= 1'b0;
          end
        end
      end else begin
        ecnt_q <= '0;
        ovld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = ovld_q;
  assign elem_index_o = oidx_q;
  assign elem_value_o = oval_q;
  assign last_elem_o = (oidx_q == 4'd15);
endmodule

[src/mtc_init.sv]
// reset sequencer: busy_o is high from reset until its two-bit counter saturates
module mtc_init import mtc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  output logic busy_o
);
  logic [1:0] cnt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else if (cnt_q != 2'd3) cnt_q <= cnt_q + 2'd1;
  end
  assign busy_o = (cnt_q != 2'd3);
endmodule

[src/model_transform_composer_core.sv]
// top level of the 4x4 model transform composer
// a request runs through the angle conversion, 24 cordic steps plus one for sine/cosine
//   (rotations only), the update with two phases per column and sixteen serial output
//   words; a new request is accepted only after the last word of the previous one
// reset: asynchronous active low; an internal identity request loads the matrix
module model_transform_composer_core import mtc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  mtc_req_if.sink    req_i,
  mtc_elem_if.source elem_o
);
  cmd_t cmd, cmd_c;
  sts_t sts;
  logic busy, rdy, vld;

  mtc_init u_init (.clk_i, .rst_ni, .busy_o(busy));

  // during init an identity request is injected, its words dropped
  logic init_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) init_q <= 1'b1;
    else if (cmd.load && busy) init_q <= 1'b1;
    else if (sts.edone) init_q <= 1'b0;
  end

  logic seeded_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) seeded_q <= 1'b0;
    else if (cmd.load) seeded_q <= 1'b1;
  end

  assign vld = seeded_q ? (req_i.valid && !init_q) : 1'b1;
  assign req_i.ready = rdy && seeded_q && !init_q;

  mtc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(vld), .in_ready_o(rdy), .sts_i(sts), .cmd_o(cmd)
  );
  assign cmd_c = cmd;

  logic ov;
  logic rdy_int;
  assign rdy_int = init_q ? 1'b1 : elem_o.ready;
  mtc_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd_c), .sts_o(sts),
    .req_type_i(seeded_q ? req_i.req_type : REQ_IDENT),
    .arg_x_i(req_i.arg_x), .arg_y_i(req_i.arg_y), .arg_z_i(req_i.arg_z),
    .angle_deg_i(req_i.angle_deg),
    .out_valid_o(ov), .out_ready_i(rdy_int),
    .elem_index_o(elem_o.elem_index), .elem_value_o(elem_o.elem_value),
    .last_elem_o(elem_o.last_elem)
  );
  assign elem_o.valid = ov && !init_q;
endmodule

[src/mtc_checker.sv]
// port-level checker for the transform composer
`include "model_transform_composer_core_assert.svh"
module mtc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [3:0] idx,
  input logic last
);
  `MTC_ASSERT_IMP(a_last_idx, clk_i, rst_ni, out_valid && last, idx == 4'd15)
  `MTC_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, out_valid, !in_ready)
  `MTC_ASSERT_NXT(a_seq, clk_i, rst_ni, out_valid && out_ready && !last,
    !out_valid || idx == $past(idx) + 4'd1)
endmodule

bind model_transform_composer_core mtc_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(req_i.valid), .in_ready(req_i.ready),
  .out_valid(elem_o.valid), .out_ready(elem_o.ready),
  .idx(elem_o.elem_index), .last(elem_o.last_elem)
);

[test/testbench.sv]
// testbench for the model transform composer: directed and random requests checked
`timescale 1ns / 100ps

module testbench;
  import mtc_pkg::*;

  // one expected output word
  typedef struct {
    logic [3:0]  index;
    logic [31:0] value;
    logic        last;
  } elem_exp_t;

  logic clk_i;
  logic rst_ni;

  mtc_req_if  req_if ();
  mtc_elem_if elem_if ();

  model_transform_composer_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .elem_o (elem_if)
  );

  // shadow copy of the matrix, column-major
  logic signed [31:0] shadow_mat [16];
  elem_exp_t          elem_queue [$];
  int                 error_count;
  int                 send_idle_pct;
  int                 stall_pct;

  // arctangent table in binary angle units, one turn is 2^32
  localparam logic [31:0] ATAN_TAB [30] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  // clock, 12 ns period
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // q32 product sum to q16.16, round half up, saturate
  function automatic logic [31:0] round_sat_q16(input longint x);
    longint q;
    q = (x + 64'sd32768) >>> 16;
    if (q > 64'sd2147483647) return 32'h7FFFFFFF;
    if (q < -64'sd2147483648) return 32'h80000000;
    return q[31:0];
  endfunction

  // q2.30 cordic output to q16.16 clamped to plus or minus one
  function automatic longint q30_to_unit(input longint v);
    longint r;
    r = (v + 8192) >>> 14;
    if (r > 65536) r = 65536;
    if (r < -65536) r = -65536;
    return r;
  endfunction

  // sine and cosine in q16.16 of an angle in degrees q16.16
  task automatic calc_sin_cos(input logic signed [31:0] deg,
                              output longint s, output longint c);
    longint p, q, r, z, x, y, dx, dy;
    logic [31:0] bam;
    bit flip;
    p = longint'(deg) * 65536;
    q = p / 360;
    r = p % 360;
    flip = 1'b0;
    // floor division, then round half up on the remainder
    if (r < 0) begin
      q -= 1;
      r += 360;
    end
    if (2 * r >= 360) q += 1;
    bam = q[31:0];
    z = longint'(signed'(bam));
    // fold into [-90, 90) degrees, negate the outputs afterward
    if (z >= (64'sd1 <<< 30)) begin
      z -= 64'sd1 <<< 31;
      flip = 1'b1;
    end else if (z < -(64'sd1 <<< 30)) begin
      z += 64'sd1 <<< 31;
      flip = 1'b1;
    end
    x = 652032874;
    y = 0;
    for (int i = 0; i < CordicSteps && i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(ATAN_TAB[i]);
      end else begin
        x += dx;
        y -= dy;
        z += longint'(ATAN_TAB[i]);
      end
    end
    c = q30_to_unit(x);
    s = q30_to_unit(y);
    if (flip) begin
      c = -c;
      s = -s;
    end
  endtask

  function automatic void load_identity();
    for (int k = 0; k < 16; k++) shadow_mat[k] = (k % 5 == 0) ? OneQ16 : 32'sd0;
  endfunction

  // premultiply the shadow matrix and queue the sixteen expected words
  task automatic compose_expected(input logic [2:0] kind, input logic signed [31:0] ax,
                                  input logic signed [31:0] ay, input logic signed [31:0] az,
                                  input logic signed [31:0] deg);
    longint s, c, ma, mb, w;
    longint arg [3];
    int ra, rb;
    elem_exp_t e;
    arg[0] = ax;
    arg[1] = ay;
    arg[2] = az;
    ra = 0;
    rb = 0;
    case (kind)
      REQ_IDENT: load_identity();
      REQ_SCALE: begin
        for (int col = 0; col < 4; col++)
          for (int row = 0; row < 3; row++)
            shadow_mat[col*4+row] = round_sat_q16(arg[row] * longint'(shadow_mat[col*4+row]));
      end
      REQ_TRANS: begin
        for (int col = 0; col < 4; col++) begin
          w = shadow_mat[col*4+3];
          for (int row = 0; row < 3; row++)
            shadow_mat[col*4+row] =
              round_sat_q16(longint'(shadow_mat[col*4+row]) * 65536 + arg[row] * w);
        end
      end
      REQ_ROTX, REQ_ROTY, REQ_ROTZ: begin
        // rows touched by each rotation axis
        if (kind == REQ_ROTX) begin ra = 1; rb = 2; end
        else if (kind == REQ_ROTY) begin ra = 2; rb = 0; end
        else begin ra = 0; rb = 1; end
        calc_sin_cos(deg, s, c);
        for (int col = 0; col < 4; col++) begin
          ma = shadow_mat[col*4+ra];
          mb = shadow_mat[col*4+rb];
          shadow_mat[col*4+ra] = round_sat_q16(c * ma - s * mb);
          shadow_mat[col*4+rb] = round_sat_q16(s * ma + c * mb);
        end
      end
      default: ;  // unused codes leave the matrix alone
    endcase
    for (int k = 0; k < 16; k++) begin
      e.index = k[3:0];
      e.value = shadow_mat[k];
      e.last  = (k == 15);
      elem_queue.push_back(e);
    end
  endtask

  // send one request, idling before it at the current rate
  task automatic send_request(input logic [2:0] kind, input logic signed [31:0] ax,
                              input logic signed [31:0] ay, input logic signed [31:0] az,
                              input logic signed [31:0] deg);
    @(posedge clk_i);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    req_if.valid     <= 1'b1;
    req_if.req_type  <= kind;
    req_if.arg_x     <= ax;
    req_if.arg_y     <= ay;
    req_if.arg_z     <= az;
    req_if.angle_deg <= deg;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    compose_expected(kind, ax, ay, az, deg);
    req_if.valid <= 1'b0;
  endtask

  // receiver ready, stalling at random
  always @(posedge clk_i) begin
    if (!rst_ni) elem_if.ready <= 1'b0;
    else elem_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // compare each accepted word with the oldest expectation
  always @(posedge clk_i) begin
    elem_exp_t e;
    if (rst_ni && elem_if.valid && elem_if.ready) begin
      if (elem_queue.size() == 0) begin
        $error("unexpected word index %0d value %h", elem_if.elem_index, elem_if.elem_value);
        error_count++;
      end else begin
        e = elem_queue.pop_front();
        if (elem_if.elem_index !== e.index) begin
          $error("elem_index expected %0d actual %0d", e.index, elem_if.elem_index);
          error_count++;
        end
        if (elem_if.elem_value !== e.value) begin
          $error("elem_value expected %h actual %h", e.value, elem_if.elem_value);
          error_count++;
        end
        if (elem_if.last_elem !== e.last) begin
          $error("last_elem expected %0b actual %0b", e.last, elem_if.last_elem);
          error_count++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (elem_queue.size() != 0) @(posedge clk_i);
  endtask

  // random angle: mostly within a few turns, sometimes any value
  function automatic logic [31:0] pick_angle();
    case ($urandom_range(3))
      0: return $urandom;
      1: return {$urandom_range(0, 1) ? -32'sd1 : 32'sd1} * ($urandom_range(720) <<< 16);
      default: return $urandom_range(32'h05A00000) - 32'h02D00000 + $urandom_range(65535);
    endcase
  endfunction

  // random scale or translation amount within plus or minus two, occasionally anything
  function automatic logic [31:0] pick_arg();
    if ($urandom_range(9) == 0) return $urandom;
    return $urandom_range(32'h00040000) - 32'h00020000;
  endfunction

  task automatic test_directed();
    send_request(REQ_IDENT, 0, 0, 0, 0);
    send_request(REQ_SCALE, 32'sh00020000, 32'sh00008000, -32'sh00010000, 0);
    send_request(REQ_TRANS, 32'sh00018000, -32'sh00030000, 32'sh7FFFFFFF, 0);
    send_request(REQ_ROTX, 0, 0, 0, 32'sh005A0000);
    send_request(REQ_ROTY, 0, 0, 0, -32'sh005A0000);
    send_request(REQ_ROTZ, 0, 0, 0, 32'sh00B40000);
    send_request(REQ_ROTZ, 0, 0, 0, 32'h80000000);
    send_request(REQ_ROTX, 0, 0, 0, 32'h7FFFFFFF);
    send_request(REQ_ROTY, 0, 0, 0, 32'sh00000001);
    send_request(REQ_RSV6, $urandom, $urandom, $urandom, $urandom);
    send_request(REQ_RSV7, $urandom, $urandom, $urandom, $urandom);
    // drive elements into saturation both ways
    send_request(REQ_SCALE, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0);
    send_request(REQ_SCALE, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 0);
    send_request(REQ_TRANS, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0);
    send_request(REQ_ROTZ, 0, 0, 0, 32'sh002D0000);
    send_request(REQ_SCALE, 0, 0, 0, 32'hFFFFFFFF);
    send_request(REQ_IDENT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
  endtask

  // random request mix: identity, transforms and now and then a reserved code
  task automatic test_random(input int count);
    logic [2:0] kind;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(11) == 0) kind = REQ_IDENT;
      else if ($urandom_range(19) == 0) kind = 3'($urandom_range(6, 7));
      else kind = 3'($urandom_range(1, 5));
      send_request(kind, pick_arg(), pick_arg(), pick_arg(), pick_angle());
    end
  endtask

  // sender holds off until every word has come back
  task automatic test_pause_drain();
    send_request(REQ_ROTX, 0, 0, 0, pick_angle());
    wait_drained();
    send_request(REQ_TRANS, pick_arg(), pick_arg(), pick_arg(), 0);
  endtask

  initial begin
    error_count   = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    load_identity();
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.req_type  = REQ_IDENT;
    req_if.arg_x     = '0;
    req_if.arg_y     = '0;
    req_if.arg_z     = '0;
    req_if.angle_deg = '0;
    elem_if.ready    = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_pause_drain();
    test_random(40);
    send_idle_pct = 84;
    test_random(40);
    send_idle_pct = 0;
    stall_pct     = 84;
    test_random(40);
    send_idle_pct = 21;
    stall_pct     = 21;
    test_random(40);

    wait_drained();
    repeat (60) @(posedge clk_i);
    if (error_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

[filelist.f]
+incdir+src
src/mtc_pkg.sv
src/mtc_if.sv
src/mtc_ctrl.sv
src/mtc_dp.sv
src/mtc_init.sv
src/model_transform_composer_core.sv
src/mtc_checker.sv
test/testbench.sv
